>>> sv/vmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmc_pkg
// shared constants and types for the vector magnitude clamp pipeline
// ----------------------------------------------------------------------------
package vmc_pkg;

    localparam int FIELD_W         = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int COMP_WIDTH_DEF  = 32;
    localparam int S_TDATA_W       = 3 * FIELD_W;
    localparam int M_TDATA_W       = 2 * FIELD_W;

    // per-item control that rides alongside the datapath
    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic lim_pos;
        logic clamp;
    } vmc_flags_t;

endpackage

>>> sv/vmc_sqrt_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmc_sqrt_stage
// one registered digit step of the floor square root, two radicand bits a step
// ----------------------------------------------------------------------------
module vmc_sqrt_stage #(
    parameter int W = 32
) (
    input  logic           aclk,
    input  logic           en,
    input  logic [2*W-1:0] rad_i,
    input  logic [W:0]     rem_i,
    input  logic [W-1:0]   root_i,
    output logic [2*W-1:0] rad_o,
    output logic [W:0]     rem_o,
    output logic [W-1:0]   root_o
);
    import vmc_pkg::*;

    logic [2*W-1:0] rad_reg, rad_next;
    logic [W:0]     rem_reg, rem_next;
    logic [W-1:0]   root_reg, root_next;
    logic [W+2:0]   trial, cand, diff;
    logic           ge;

    always_comb begin
        cand      = {rem_i, rad_i[2*W-1 -: 2]};
        trial     = {1'b0, root_i, 2'b01};
        ge        = (cand >= trial);
        diff      = cand - trial;
        // remainder stays within twice the root, so it fits after truncation
        rem_next  = ge ? diff[W:0] : cand[W:0];
        root_next = {root_i[W-2:0], ge};
        rad_next  = {rad_i[2*W-3:0], 2'b00};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign rad_o  = rad_reg;
    assign rem_o  = rem_reg;
    assign root_o = root_reg;

endmodule

>>> sv/vmc_div_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmc_div_stage
// one registered restoring division step for both components, shared divisor
// ----------------------------------------------------------------------------
module vmc_div_stage #(
    parameter int W = 32
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] div_i,
    input  logic [W-1:0] remx_i,
    input  logic [W-1:0] lowx_i,
    input  logic [W-1:0] remy_i,
    input  logic [W-1:0] lowy_i,
    output logic [W-1:0] div_o,
    output logic [W-1:0] remx_o,
    output logic [W-1:0] lowx_o,
    output logic [W-1:0] remy_o,
    output logic [W-1:0] lowy_o
);
    import vmc_pkg::*;

    logic [W-1:0] div_reg;
    logic [W-1:0] remx_reg, remx_next, lowx_reg, lowx_next;
    logic [W-1:0] remy_reg, remy_next, lowy_reg, lowy_next;
    logic [W:0]   tx, ty, dx, dy, dext;
    logic         gex, gey;

    always_comb begin
        dext = {1'b0, div_i};
        tx   = {remx_i, lowx_i[W-1]};
        ty   = {remy_i, lowy_i[W-1]};
        gex  = (tx >= dext);
        gey  = (ty >= dext);
        dx   = tx - dext;
        dy   = ty - dext;
        // partial remainder stays below the divisor; quotient bits shift into low
        remx_next = gex ? dx[W-1:0] : tx[W-1:0];
        remy_next = gey ? dy[W-1:0] : ty[W-1:0];
        lowx_next = {lowx_i[W-2:0], gex};
        lowy_next = {lowy_i[W-2:0], gey};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            div_reg  <= div_i;
            remx_reg <= remx_next;
            lowx_reg <= lowx_next;
            remy_reg <= remy_next;
            lowy_reg <= lowy_next;
        end
    end

    assign div_o  = div_reg;
    assign remx_o = remx_reg;
    assign lowx_o = lowx_reg;
    assign remy_o = remy_reg;
    assign lowy_o = lowy_reg;

endmodule

>>> sv/vector_magnitude_clamp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_magnitude_clamp
// limits the length of a 2d fixed point vector to a given limit
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit up)              | tuser
// s_      | in  | vec_x, vec_y, max_len (32 each)  | -
// m_      | out | out_x, out_y (32 each)           | was_clamped
//
// one word accepted per cycle unless m_ stalls; the pipeline runs through the
// magnitude, multiply and compare stages, one square root digit per stage,
// one quotient bit per stage, then the output register.
// aresetn clears only the valid bits; the datapath carries no reset.
// a stall on m_ freezes the whole pipeline and s_tready drops with it.
// ----------------------------------------------------------------------------
module vector_magnitude_clamp #(
    parameter int FRAC_BITS  = vmc_pkg::FRAC_BITS_DEF,
    parameter int COMP_WIDTH = vmc_pkg::COMP_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [vmc_pkg::S_TDATA_W-1:0]  s_tdata,   // vec_x, vec_y, max_len
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [vmc_pkg::M_TDATA_W-1:0]  m_tdata,   // out_x, out_y
    output logic [0:0]                     m_tuser    // was_clamped
);
    import vmc_pkg::*;

    localparam int W = COMP_WIDTH;
    // scaling is independent of the binary point; kept for the format only
    localparam int FB = FRAC_BITS;

    logic adv;

    // stage 0: magnitudes
    logic         v0_reg;
    logic [W-1:0] ax0_reg, ay0_reg, al0_reg, rx0_reg, ry0_reg;
    vmc_flags_t   f0_reg, f0_next;
    logic [W-1:0] in_x, in_y, in_l;

    // stage 1: products
    logic           v1_reg;
    logic [2*W-1:0] sqx1_reg, sqy1_reg, sql1_reg, px1_reg, py1_reg;
    logic [W-1:0]   rx1_reg, ry1_reg;
    vmc_flags_t     f1_reg;

    // stage 2: sum and compare
    logic           v2_reg;
    logic [2*W-1:0] s2_reg, px2_reg, py2_reg;
    logic [W-1:0]   rx2_reg, ry2_reg;
    vmc_flags_t     f2_reg, f2_next;
    logic [2*W-1:0] s2_next;

    // square root pipeline
    logic           sq_vld  [0:W];
    vmc_flags_t     sq_flg  [0:W];
    logic [W-1:0]   sq_rx   [0:W];
    logic [W-1:0]   sq_ry   [0:W];
    logic [2*W-1:0] sq_px   [0:W];
    logic [2*W-1:0] sq_py   [0:W];
    logic [2*W-1:0] sq_rad  [0:W];
    logic [W:0]     sq_rem  [0:W];
    logic [W-1:0]   sq_root [0:W];

    // division pipeline
    logic         dv_vld  [0:W];
    vmc_flags_t   dv_flg  [0:W];
    logic [W-1:0] dv_rx   [0:W];
    logic [W-1:0] dv_ry   [0:W];
    logic [W-1:0] dv_div  [0:W];
    logic [W-1:0] dv_remx [0:W];
    logic [W-1:0] dv_lowx [0:W];
    logic [W-1:0] dv_remy [0:W];
    logic [W-1:0] dv_lowy [0:W];

    // output register
    logic         mv_reg;
    logic [W-1:0] ox_reg, oy_reg, ox_next, oy_next;
    logic         oc_reg;

    assign adv      = !mv_reg || m_tready;
    assign s_tready = adv;

    assign in_x = s_tdata[W-1:0];
    assign in_y = s_tdata[FIELD_W +: W];
    assign in_l = s_tdata[2*FIELD_W +: W];

    always_comb begin
        f0_next.neg_x   = in_x[W-1];
        f0_next.neg_y   = in_y[W-1];
        f0_next.lim_pos = !in_l[W-1] && (in_l != '0);
        f0_next.clamp   = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= s_tvalid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ax0_reg <= in_x[W-1] ? W'(-in_x) : in_x;
            ay0_reg <= in_y[W-1] ? W'(-in_y) : in_y;
            al0_reg <= in_l[W-1] ? W'(-in_l) : in_l;
            rx0_reg <= in_x;
            ry0_reg <= in_y;
            f0_reg  <= f0_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sqx1_reg <= {{W{1'b0}}, ax0_reg} * {{W{1'b0}}, ax0_reg};
            sqy1_reg <= {{W{1'b0}}, ay0_reg} * {{W{1'b0}}, ay0_reg};
            sql1_reg <= {{W{1'b0}}, al0_reg} * {{W{1'b0}}, al0_reg};
            px1_reg  <= {{W{1'b0}}, ax0_reg} * {{W{1'b0}}, al0_reg};
            py1_reg  <= {{W{1'b0}}, ay0_reg} * {{W{1'b0}}, al0_reg};
            rx1_reg  <= rx0_reg;
            ry1_reg  <= ry0_reg;
            f1_reg   <= f0_reg;
        end
    end

    always_comb begin
        // sum of two squares is at most 2^(2W-1), so it never carries out
        s2_next       = sqx1_reg + sqy1_reg;
        f2_next       = f1_reg;
        f2_next.clamp = (s2_next > sql1_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_reg  <= s2_next;
            px2_reg <= px1_reg;
            py2_reg <= py1_reg;
            rx2_reg <= rx1_reg;
            ry2_reg <= ry1_reg;
            f2_reg  <= f2_next;
        end
    end

    always_comb begin
        sq_vld[0]  = v2_reg;
        sq_flg[0]  = f2_reg;
        sq_rx[0]   = rx2_reg;
        sq_ry[0]   = ry2_reg;
        sq_px[0]   = px2_reg;
        sq_py[0]   = py2_reg;
        sq_rad[0]  = s2_reg;
        sq_rem[0]  = '0;
        sq_root[0] = '0;
    end

    for (genvar k = 0; k < W; k++) begin : g_sqrt
        vmc_sqrt_stage #(.W(W)) u_sqrt (
            .aclk   (aclk),
            .en     (adv),
            .rad_i  (sq_rad[k]),
            .rem_i  (sq_rem[k]),
            .root_i (sq_root[k]),
            .rad_o  (sq_rad[k+1]),
            .rem_o  (sq_rem[k+1]),
            .root_o (sq_root[k+1])
        );

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_vld[k+1] <= 1'b0;
            end else if (adv) begin
                sq_vld[k+1] <= sq_vld[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                sq_flg[k+1] <= sq_flg[k];
                sq_rx[k+1]  <= sq_rx[k];
                sq_ry[k+1]  <= sq_ry[k];
                sq_px[k+1]  <= sq_px[k];
                sq_py[k+1]  <= sq_py[k];
            end
        end
    end

    // high half of each product is below the root, so the quotient fits W bits
    always_comb begin
        dv_vld[0]  = sq_vld[W];
        dv_flg[0]  = sq_flg[W];
        dv_rx[0]   = sq_rx[W];
        dv_ry[0]   = sq_ry[W];
        dv_div[0]  = sq_root[W];
        dv_remx[0] = sq_px[W][2*W-1:W];
        dv_lowx[0] = sq_px[W][W-1:0];
        dv_remy[0] = sq_py[W][2*W-1:W];
        dv_lowy[0] = sq_py[W][W-1:0];
    end

    for (genvar k = 0; k < W; k++) begin : g_div
        vmc_div_stage #(.W(W)) u_div (
            .aclk   (aclk),
            .en     (adv),
            .div_i  (dv_div[k]),
            .remx_i (dv_remx[k]),
            .lowx_i (dv_lowx[k]),
            .remy_i (dv_remy[k]),
            .lowy_i (dv_lowy[k]),
            .div_o  (dv_div[k+1]),
            .remx_o (dv_remx[k+1]),
            .lowx_o (dv_lowx[k+1]),
            .remy_o (dv_remy[k+1]),
            .lowy_o (dv_lowy[k+1])
        );

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_vld[k+1] <= 1'b0;
            end else if (adv) begin
                dv_vld[k+1] <= dv_vld[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_flg[k+1] <= dv_flg[k];
                dv_rx[k+1]  <= dv_rx[k];
                dv_ry[k+1]  <= dv_ry[k];
            end
        end
    end

    always_comb begin
        if (!dv_flg[W].clamp) begin
            ox_next = dv_rx[W];
            oy_next = dv_ry[W];
        end else if (!dv_flg[W].lim_pos) begin
            ox_next = '0;
            oy_next = '0;
        end else begin
            ox_next = dv_flg[W].neg_x ? W'(-dv_lowx[W]) : dv_lowx[W];
            oy_next = dv_flg[W].neg_y ? W'(-dv_lowy[W]) : dv_lowy[W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (adv) begin
            mv_reg <= dv_vld[W];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ox_reg <= ox_next;
            oy_reg <= oy_next;
            oc_reg <= dv_flg[W].clamp;
        end
    end

    assign m_tvalid   = mv_reg;
    assign m_tdata    = {(FIELD_W)'(oy_reg), (FIELD_W)'(ox_reg)};
    assign m_tuser[0] = oc_reg;

`ifndef ASSERT_OFF
    // a scaled word always has a nonzero divisor
    assert property (@(posedge aclk) disable iff (!aresetn)
        sq_vld[W] && sq_flg[W].clamp && sq_flg[W].lim_pos |-> sq_root[W] != '0)
        else $error("zero square root on a scaled word");

    // partial remainder below divisor at the end of division
    assert property (@(posedge aclk) disable iff (!aresetn)
        dv_vld[W] && dv_flg[W].clamp && dv_flg[W].lim_pos
            |-> dv_remx[W] < dv_div[W] && dv_remy[W] < dv_div[W])
        else $error("division remainder out of range");

    // a stall freezes the pipeline valid bits
    assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(v2_reg) && $stable(sq_vld[W]) && $stable(dv_vld[W]))
        else $error("pipeline moved during a stall");

    // an unclamped word leaves the vector untouched
    assert property (@(posedge aclk) disable iff (!aresetn)
        adv && dv_vld[W] && !dv_flg[W].clamp |=> ox_reg == $past(dv_rx[W]) && FB >= 0)
        else $error("unclamped word altered");
`endif

endmodule

>>> tb/sv/tb_vector_magnitude_clamp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vector_magnitude_clamp
// self-checking bench: drives vectors and limits on s_, predicts each clamped
// result in a behavioral model and compares it with every word taken from m_
// ----------------------------------------------------------------------------
module tb_vector_magnitude_clamp;
    import vmc_pkg::*;

    localparam int LATENCY = 2 * COMP_WIDTH_DEF + 4;

    typedef struct packed {
        logic [31:0] y;
        logic [31:0] x;
        logic        clamped;
    } clamp_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0]           m_tuser;

    clamp_result_t expected_q[$];
    int            error_count = 0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            hold_off_cycles = 0;

    vector_magnitude_clamp uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        #50_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] bitv;
        logic [63:0] rem;
        root = 0;
        rem  = n;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic [31:0] scale_component(input logic signed [31:0] c,
                                                    input logic [63:0] lim,
                                                    input logic [63:0] root);
        logic [63:0] mag;
        logic [63:0] q;
        mag = c[31] ? 64'(-64'(c)) : 64'(c);
        q   = (mag * lim) / root;
        return c[31] ? 32'(-q) : q[31:0];
    endfunction

    function automatic clamp_result_t clamp_vector(input logic signed [31:0] x,
                                                   input logic signed [31:0] y,
                                                   input logic signed [31:0] lim);
        clamp_result_t r;
        logic [63:0] ax, ay, al, sq_len, sq_lim, root;
        ax = x[31] ? 64'(-64'(x)) : 64'(x);
        ay = y[31] ? 64'(-64'(y)) : 64'(y);
        al = lim[31] ? 64'(-64'(lim)) : 64'(lim);
        sq_len = ax * ax + ay * ay;
        sq_lim = al * al;
        if (sq_len > sq_lim) begin
            r.clamped = 1'b1;
            if (lim <= 0) begin
                r.x = '0;
                r.y = '0;
            end else begin
                root = floor_sqrt(sq_len);
                if (root == 0) root = 1;
                r.x = scale_component(x, al, root);
                r.y = scale_component(y, al, root);
            end
        end else begin
            r.clamped = 1'b0;
            r.x = x;
            r.y = y;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    // receiver side: random stalls plus an optional long hold-off
    always @(posedge aclk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        clamp_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected word", m_tdata[31:0], '0);
            end else begin
                want = expected_q.pop_front();
                if (m_tdata[31:0] !== want.x)
                    report_mismatch("out_x", m_tdata[31:0], want.x);
                if (m_tdata[63:32] !== want.y)
                    report_mismatch("out_y", m_tdata[63:32], want.y);
                if (m_tuser[0] !== want.clamped)
                    report_mismatch("was_clamped", 32'(m_tuser[0]), 32'(want.clamped));
            end
        end
    end

    // valid stays up after an accept unless the next word idles first
    task automatic send_vector(input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] lim);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {lim, y, x};
        expected_q.push_back(clamp_vector(x, y, lim));
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [31:0] rand_field();
        case ($urandom_range(5))
            0: return $urandom_range(65535) - 32768;
            1: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed_cases();
        send_vector(32'h0, 32'h0, 32'h0);                  // zero vector, zero limit
        send_vector(32'h0001_0000, 32'h0, 32'h0);          // zero limit clamps
        send_vector(32'h0003_0000, 32'h0004_0000, 32'hFFFE_0000); // negative limit
        send_vector(32'h0003_0000, 32'h0004_0000, 32'hFFFA_0000); // negative within
        send_vector(32'h0003_0000, 32'h0004_0000, 32'h0005_0000); // on the boundary
        send_vector(32'h0003_0000, 32'h0004_0000, 32'h0002_0000);
        send_vector(32'hFFFD_0000, 32'hFFFC_0000, 32'h0001_0000);
        send_vector(32'h8000_0000, 32'h8000_0000, 32'h0000_0001);
        send_vector(32'h8000_0000, 32'h0, 32'h7FFF_FFFF);  // most negative clamps to 8000_0001
        send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_vector(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
        send_vector(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001);
        send_vector(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_vector(32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333);
        send_vector(32'hAAAA_AAAA, 32'h5555_5555, 32'hCCCC_CCCC);
    endtask

    task automatic test_random_vectors(input int count, input int idle_pct,
                                       input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_vector(rand_field(), rand_field(), rand_field());
    endtask

    task automatic test_backpressure();
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_off_cycles <= 3 * LATENCY;
        repeat (150) send_vector(rand_field(), rand_field(), rand_field());
    endtask

    initial begin
        int waited;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_random_vectors(320, 0, 0);
        test_random_vectors(320, 45, 0);
        test_random_vectors(320, 0, 45);
        test_random_vectors(320, 33, 33);
        test_backpressure();
        s_tvalid <= 1'b0;
        recv_stall_pct = 0;
        waited = 0;
        while (expected_q.size() != 0 && waited < 100_000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (LATENCY + 10) @(posedge aclk);
        if (expected_q.size() == 0 && error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/vmc_pkg.sv
sv/vmc_sqrt_stage.sv
sv/vmc_div_stage.sv
sv/vector_magnitude_clamp.sv
tb/sv/tb_vector_magnitude_clamp.sv
